// ----- rtl/core/square_matrix_multiply_core_assert.svh -----
// Assertion macros for the square matrix multiply core.
// Used by the top level; no other dependencies.
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SMM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SMM_ASSERT(lbl, prop, msg) `SMM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define SMM_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SMM_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/smm_pkg.sv -----
// Shared types and constants for the square matrix multiply core.
// No dependencies.
package smm_pkg;

  localparam int IDX_W      = 3;
  localparam int ELEM_IN_W  = 16;
  localparam int PROD_W     = 32;
  localparam int SIZE_W     = 2;
  localparam int DIM_W      = 4;
  localparam int DIM_LIMIT  = 8;

  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 2'd3;

  typedef struct packed {
    logic                 store_en;
    logic                 last;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [ELEM_IN_W-1:0] a_elem;
    logic [ELEM_IN_W-1:0] b_elem;
  } load_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ----- rtl/core/smm_queue.sv -----
// Two-entry queue of classified load items between front and back.
// Depends on smm_pkg.
module smm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  smm_pkg::load_item_t   item_i,
  input  logic                  pop_i,
  output smm_pkg::load_item_t   item_o,
  output smm_pkg::queue_status_t status_o
);
  import smm_pkg::*;

  load_item_t  mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = mem_q[rd_ptr_q];
  assign status_o.valid = (count_q != 2'd0);
  assign status_o.full  = (count_q == 2'd2);

endmodule

// ----- rtl/core/smm_front.sv -----
// Input side: accepts load items, classifies them and pushes them to the queue.
// Depends on smm_pkg.
module smm_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [smm_pkg::IDX_W-1:0]       row_i,
  input  logic [smm_pkg::IDX_W-1:0]       col_i,
  input  logic signed [smm_pkg::ELEM_IN_W-1:0] a_elem_i,
  input  logic signed [smm_pkg::ELEM_IN_W-1:0] b_elem_i,
  input  logic                            last_i,
  input  smm_pkg::queue_status_t          status_i,
  output logic                            push_o,
  output smm_pkg::load_item_t             item_o
);
  import smm_pkg::*;

  logic row_ok;
  logic col_ok;

  assign row_ok = (int'(row_i) < MAX_DIM);
  assign col_ok = (int'(col_i) < MAX_DIM);

  assign in_stall_o = status_i.full;
  assign push_o     = in_valid_i && !status_i.full;

  assign item_o.store_en = row_ok && col_ok;
  assign item_o.last     = last_i;
  assign item_o.row      = row_i;
  assign item_o.col      = col_i;
  assign item_o.a_elem   = $unsigned(a_elem_i);
  assign item_o.b_elem   = $unsigned(b_elem_i);

endmodule

// ----- rtl/core/smm_back.sv -----
// Execution side: element stores, read sequencer, multiply-accumulate pipe and
// output register. Depends on smm_pkg.
module smm_back #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smm_pkg::queue_status_t         q_status_i,
  input  smm_pkg::load_item_t            q_item_i,
  output logic                           pop_o,
  input  logic [smm_pkg::SIZE_W-1:0]     size_log2_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smm_pkg::IDX_W-1:0]      out_row_o,
  output logic [smm_pkg::IDX_W-1:0]      out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0] product_elem_o,
  output logic                           run_end_o
);
  import smm_pkg::*;

  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int DIM_CAP   = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   i_q, j_q, k_q, dim_m1_q;
  logic               s1_v_q, s1_first_q, s1_last_q;
  logic               s2_v_q, s2_first_q, s2_last_q;
  logic               acc_done_q;
  logic               out_valid_q, out_end_q;
  logic [IDX_W-1:0]   out_row_q, out_col_q;
  logic [PROD_W-1:0]  out_prod_q;

  logic [ELEM_BITS-1:0] a_mem [MEM_DEPTH];
  logic [ELEM_BITS-1:0] b_mem [MEM_DEPTH];
  logic [ELEM_BITS-1:0] rd_a_q, rd_b_q;
  logic [PROD_W-1:0]    prod_q, acc_q;

  logic [DIM_W-1:0]   dim_raw, dim_sel;
  logic [IDX_W-1:0]   dim_m1_d;
  logic [ADDR_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
  logic               issue, k_last, out_free, load_out, elem_last;
  logic signed [PROD_W-1:0] a_ext, b_ext;

  assign dim_raw  = DIM_W'(1) << size_log2_i;
  assign dim_sel  = (dim_raw > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : dim_raw;
  assign dim_m1_d = IDX_W'(dim_sel - DIM_W'(1));

  assign wr_addr   = ADDR_W'(q_item_i.row) * ADDR_W'(MAX_DIM) + ADDR_W'(q_item_i.col);
  assign rd_a_addr = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign rd_b_addr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

  assign pop_o     = (state_q == ST_IDLE) && q_status_i.valid;
  assign issue     = (state_q == ST_CALC);
  assign k_last    = (k_q == dim_m1_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DRAIN) && acc_done_q && out_free;
  assign elem_last = (i_q == dim_m1_q) && (j_q == dim_m1_q);

  assign a_ext = PROD_W'(signed'(rd_a_q));
  assign b_ext = PROD_W'(signed'(rd_b_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      dim_m1_q    <= '0;
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      acc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_end_q   <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_prod_q  <= '0;
    end else begin
      s1_v_q     <= issue;
      s1_first_q <= (k_q == '0);
      s1_last_q  <= k_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;

      if (s2_v_q && s2_last_q) begin
        acc_done_q <= 1'b1;
      end else if (load_out) begin
        acc_done_q <= 1'b0;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
        out_row_q   <= i_q;
        out_col_q   <= j_q;
        out_prod_q  <= acc_q;
        out_end_q   <= elem_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (pop_o && q_item_i.last) begin
            dim_m1_q <= dim_m1_d;
            i_q      <= '0;
            j_q      <= '0;
            k_q      <= '0;
            state_q  <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (k_last) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            k_q <= '0;
            if (elem_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_CALC;
              if (j_q == dim_m1_q) begin
                j_q <= '0;
                i_q <= i_q + IDX_W'(1);
              end else begin
                j_q <= j_q + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.store_en) begin
      a_mem[wr_addr] <= ELEM_BITS'(q_item_i.a_elem);
      b_mem[wr_addr] <= ELEM_BITS'(q_item_i.b_elem);
    end
    rd_a_q <= a_mem[rd_a_addr];
    rd_b_q <= b_mem[rd_b_addr];
    prod_q <= PROD_W'(a_ext * b_ext);
    if (s2_v_q) begin
      acc_q <= s2_first_q ? prod_q : acc_q + prod_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign product_elem_o = signed'(out_prod_q);
  assign run_end_o      = out_end_q;

endmodule

// ----- rtl/core/square_matrix_multiply_core.sv -----
// Square matrix multiply core: loads A and B element by element, then streams
// C = A * B in row-major order. The back end pops load items from the two-entry
// queue while idle; the item marked last then starts a run in which each
// product element is formed by dim reads through one registered store port pair
// and one 32-bit multiply-accumulate, then passes the multiply, accumulate and
// output-register stages; output stalls hold the run. dim is 2**size_log2,
// capped at MAX_DIM and 8. Loads queue up while a run is in progress.
// Store entries never written since reset read back as arbitrary values.
// Depends on smm_pkg, smm_front, smm_queue, smm_back and the assertion header.
module square_matrix_multiply_core #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [smm_pkg::SIZE_W-1:0]           cfg_size_log2_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [smm_pkg::IDX_W-1:0]            row_i,
  input  logic [smm_pkg::IDX_W-1:0]            col_i,
  input  logic signed [smm_pkg::ELEM_IN_W-1:0] a_elem_i,
  input  logic signed [smm_pkg::ELEM_IN_W-1:0] b_elem_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [smm_pkg::IDX_W-1:0]            out_row_o,
  output logic [smm_pkg::IDX_W-1:0]            out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0]    product_elem_o,
  output logic                                 run_end_o
);
  import smm_pkg::*;

  logic [SIZE_W-1:0] cfg_size_q;
  queue_status_t     q_status;
  load_item_t        front_item, q_item;
  logic              push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= SIZE_LOG2_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_size_q <= cfg_size_log2_i;
    end
  end

  smm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_i      (row_i),
    .col_i      (col_i),
    .a_elem_i   (a_elem_i),
    .b_elem_i   (b_elem_i),
    .last_i     (last_i),
    .status_i   (q_status),
    .push_o     (push),
    .item_o     (front_item)
  );

  smm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_status)
  );

  smm_back #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .size_log2_i    (cfg_size_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .product_elem_o (product_elem_o),
    .run_end_o      (run_end_o)
  );

`include "square_matrix_multiply_core_assert.svh"

  `SMM_ASSERT(a_run_end_diag, out_valid_o && run_end_o |-> out_row_o == out_col_o, "run end off diagonal")
  `SMM_ASSERT(a_out_in_dim, out_valid_o |-> ((out_row_o >> cfg_size_q) == 0) && ((out_col_o >> cfg_size_q) == 0), "product index beyond dimension")
  `SMM_ASSERT(a_queue_full_valid, q_status.full |-> q_status.valid, "queue full without entries")

endmodule
